@@ rtl/ubfc_pkg.sv @@
// Shared types and constants for the UART buffer and flow control block.
`timescale 1ns / 1ps

package ubfc_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CTS_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTS_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTS_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RTS_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RTS_LEVEL = 3'd4;

  localparam logic [CFG_DATA_W-1:0] CTS_THR_RESET = 6'd32;

  // Commands
  localparam logic [2:0] CMD_RX      = 3'd0;
  localparam logic [2:0] CMD_TX_DONE = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_PEEK    = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RX_EMPTY = 3'd1;
  localparam logic [2:0] ST_TX_FULL  = 3'd2;
  localparam logic [2:0] ST_RX_OVF   = 3'd3;
  localparam logic [2:0] ST_RX_ERR   = 3'd4;
  localparam logic [2:0] ST_RTS_HOLD = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_in;
    logic [2:0] rx_error_flags;
    logic       tx_reg_free;
    logic       rts_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] tx_byte;
    logic       tx_strobe;
    logic       cts_level;
    logic [5:0] rx_fill;
    logic [5:0] tx_fill;
    logic [2:0] status;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;  // word accepted: update buffers, launch memory reads
    logic load;  // capture result into the output register
  } ctl_t;

endpackage

@@ rtl/ubfc_ctrl.sv @@
// Controller: input/output handshake sequencing for the UART buffer block.
`timescale 1ns / 1ps

module ubfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output ubfc_pkg::ctl_t ctl_o
);
  import ubfc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   exec;
  logic   load;

  assign exec = in_valid_i & in_ready_q;
  // output register is free, or its word leaves this cycle
  assign load = (state_q == S_FINISH) & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // a word leaving with no new one loading empties the output register
      if (out_valid_q && out_ready_i && !load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (exec) begin
            state_q    <= S_FINISH;
            in_ready_q <= 1'b0;
          end
        end
        S_FINISH: begin
          if (load) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign ctl_o.exec  = exec;
  assign ctl_o.load  = load;

endmodule

@@ rtl/ubfc_datapath.sv @@
// Datapath: receive/transmit ring buffers, flow control and configuration registers.
`timescale 1ns / 1ps

module ubfc_datapath #(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ubfc_pkg::ctl_t                      ctl_i,
  input  ubfc_pkg::in_word_t                  in_data_i,
  input  logic                                cfg_we_i,
  input  logic [ubfc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ubfc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output ubfc_pkg::out_word_t                 out_data_o
);
  import ubfc_pkg::*;

  localparam int unsigned RX_AW   = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW   = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW   = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW   = $clog2(TX_DEPTH + 1);
  localparam int unsigned CMP_W   = (RX_CW > CFG_DATA_W) ? RX_CW : CFG_DATA_W;

  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
  localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

  // Buffer storage
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rdata_q;
  logic [7:0] tx_rdata_q;

  // Buffer state
  logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RX_CW-1:0] rx_count_q, rx_count_d;
  logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TX_CW-1:0] tx_count_q, tx_count_d;
  logic             cts_q, cts_d;
  logic             rx_we, tx_we;

  // Configuration
  logic                  cts_en_q, cts_en_d;
  logic                  cts_act_q, cts_act_d;
  logic [CFG_DATA_W-1:0] cts_thr_q, cts_thr_d;
  logic                  rts_en_q, rts_en_d;
  logic                  rts_act_q, rts_act_d;

  // Per-word result pieces held until the output register loads
  logic       rd_sel_q, rd_sel_d;
  logic       txq_sel_q, txq_sel_d;
  logic       strobe_q, strobe_d;
  logic [7:0] tx_direct_q, tx_direct_d;
  logic [2:0] status_q, status_d;

  out_word_t out_q;

  logic [RX_CW-1:0] rx_count_inc, rx_count_dec;
  logic             cfg_cts_hit;

  assign rx_count_inc = rx_count_q + RX_CW'(1);
  assign rx_count_dec = rx_count_q - RX_CW'(1);

  always_comb begin
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    rx_count_d  = rx_count_q;
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    tx_count_d  = tx_count_q;
    cts_d       = cts_q;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    rd_sel_d    = 1'b0;
    txq_sel_d   = 1'b0;
    strobe_d    = 1'b0;
    tx_direct_d = 8'd0;
    status_d    = ST_OK;

    cts_en_d    = cts_en_q;
    cts_act_d   = cts_act_q;
    cts_thr_d   = cts_thr_q;
    rts_en_d    = rts_en_q;
    rts_act_d   = rts_act_q;
    cfg_cts_hit = 1'b0;

    if (ctl_i.exec) begin
      case (in_data_i.cmd)
        CMD_RX: begin
          if (in_data_i.rx_error_flags != 3'd0) begin
            status_d = ST_RX_ERR;
          end else if (rx_count_q == RX_FULL) begin
            status_d = ST_RX_OVF;
          end else begin
            rx_we      = 1'b1;
            rx_head_d  = (rx_head_q == RX_LAST) ? '0 : rx_head_q + RX_AW'(1);
            rx_count_d = rx_count_inc;
            if (cts_en_q && (CMP_W'(rx_count_inc) >= CMP_W'(cts_thr_q))) begin
              cts_d = 1'b0;
            end
          end
        end
        CMD_TX_DONE: begin
          if (rts_en_q && (in_data_i.rts_level != rts_act_q)) begin
            status_d = ST_RTS_HOLD;
          end else if (tx_count_q != '0) begin
            txq_sel_d  = 1'b1;
            strobe_d   = 1'b1;
            tx_tail_d  = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + TX_AW'(1);
            tx_count_d = tx_count_q - TX_CW'(1);
          end
        end
        CMD_WRITE: begin
          if (tx_count_q == TX_FULL) begin
            status_d = ST_TX_FULL;
          end else if ((tx_count_q != '0) || !in_data_i.tx_reg_free) begin
            tx_we      = 1'b1;
            tx_head_d  = (tx_head_q == TX_LAST) ? '0 : tx_head_q + TX_AW'(1);
            tx_count_d = tx_count_q + TX_CW'(1);
          end else begin
            // queue empty and transmitter free: bypass the buffer
            tx_direct_d = in_data_i.data_in;
            strobe_d    = 1'b1;
          end
        end
        CMD_READ: begin
          if (rx_count_q == '0) begin
            status_d = ST_RX_EMPTY;
          end else begin
            rd_sel_d   = 1'b1;
            rx_tail_d  = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + RX_AW'(1);
            rx_count_d = rx_count_dec;
            if (cts_en_q && (CMP_W'(rx_count_dec) < CMP_W'(cts_thr_q))) begin
              cts_d = 1'b1;
            end
          end
        end
        CMD_PEEK: begin
          if (rx_count_q == '0) begin
            status_d = ST_RX_EMPTY;
          end else begin
            rd_sel_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CTS_EN: begin
          cts_en_d    = cfg_wdata_i[0];
          cfg_cts_hit = 1'b1;
        end
        CFG_CTS_LEVEL: begin
          cts_act_d   = cfg_wdata_i[0];
          cfg_cts_hit = 1'b1;
        end
        CFG_CTS_THR: begin
          cts_thr_d   = cfg_wdata_i;
          cfg_cts_hit = 1'b1;
        end
        CFG_RTS_EN:    rts_en_d  = cfg_wdata_i[0];
        CFG_RTS_LEVEL: rts_act_d = cfg_wdata_i[0];
        default: begin
        end
      endcase
      // a CTS register write with CTS enabled re-evaluates the fill level against the threshold
      if (cfg_cts_hit && cts_en_d) begin
        cts_d = CMP_W'(rx_count_q) < CMP_W'(cts_thr_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q  <= '0;
      rx_tail_q  <= '0;
      rx_count_q <= '0;
      tx_head_q  <= '0;
      tx_tail_q  <= '0;
      tx_count_q <= '0;
      cts_q      <= 1'b1;
      cts_en_q   <= 1'b0;
      cts_act_q  <= 1'b0;
      cts_thr_q  <= CTS_THR_RESET;
      rts_en_q   <= 1'b0;
      rts_act_q  <= 1'b0;
    end else begin
      rx_head_q  <= rx_head_d;
      rx_tail_q  <= rx_tail_d;
      rx_count_q <= rx_count_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      tx_count_q <= tx_count_d;
      cts_q      <= cts_d;
      cts_en_q   <= cts_en_d;
      cts_act_q  <= cts_act_d;
      cts_thr_q  <= cts_thr_d;
      rts_en_q   <= rts_en_d;
      rts_act_q  <= rts_act_d;
    end
  end

  // Memories: one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_head_q] <= in_data_i.data_in;
    end
    if (ctl_i.exec) begin
      rx_rdata_q <= rx_mem[rx_tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_head_q] <= in_data_i.data_in;
    end
    if (ctl_i.exec) begin
      tx_rdata_q <= tx_mem[tx_tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      rd_sel_q    <= rd_sel_d;
      txq_sel_q   <= txq_sel_d;
      strobe_q    <= strobe_d;
      tx_direct_q <= tx_direct_d;
      status_q    <= status_d;
    end
  end

  // Output register; buffer state is already updated when this loads
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      out_q.read_byte <= rd_sel_q ? rx_rdata_q : 8'd0;
      out_q.tx_byte   <= txq_sel_q ? tx_rdata_q : tx_direct_q;
      out_q.tx_strobe <= strobe_q;
      out_q.cts_level <= cts_en_q & (cts_q ? cts_act_q : ~cts_act_q);
      out_q.rx_fill   <= 6'(rx_count_q);
      out_q.tx_fill   <= 6'(tx_count_q);
      out_q.status    <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/uart_buffer_flow_control_core.sv @@
// UART receive/transmit ring buffers with RTS/CTS flow control.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one event word:
//   byte received, transmit complete, software write, read or peek.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result word per event: read byte, byte for the transmit data register
//   with its strobe, CTS line level, both fill counts and a status code.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   with no read-back; write them only while idle.
// Timing:
//   The result is registered twice: the result pieces and memory reads are
//   captured when the event word is accepted, then the output register loads.
//   The load step comes from the registered read port of the buffer memories,
//   and a new event word is taken only after the previous result has loaded.
//   If the receiver stalls, the finished result waits in the datapath and
//   the output register holds its word; no new event is taken until it moves.
// Reset:
//   Pointers and counts clear, CTS is held asserted, configuration returns to
//   its defaults. Buffer contents are undefined until written.
`timescale 1ns / 1ps

module uart_buffer_flow_control_core #(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ubfc_pkg::in_word_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ubfc_pkg::out_word_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [ubfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ubfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ubfc_pkg::*;

  ctl_t ctl;

  ubfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  ubfc_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // one word in flight: an accepted word blocks the input until its result loads
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  // a transmit strobe only accompanies a successful event
  a_strobe_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.tx_strobe) |-> (out_data_o.status == ST_OK))
    else $error("tx strobe with non-ok status");

  // no byte is shown to the transmitter without its strobe
  a_tx_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.tx_strobe) |-> (out_data_o.tx_byte == 8'd0))
    else $error("tx byte nonzero without strobe");

  // empty-read result never carries data
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_RX_EMPTY)) |-> (out_data_o.read_byte == 8'd0))
    else $error("read byte nonzero on empty receive buffer");
`endif

endmodule

@@ bench/tb_uart_buffer_flow_control_core.sv @@
// Self-checking testbench for the UART ring buffer and RTS/CTS flow control core.
`timescale 1ns / 1ps

module tb_uart_buffer_flow_control_core;
  import ubfc_pkg::*;

  localparam int RX_DEPTH      = 32;
  localparam int TX_DEPTH      = 32;
  localparam int PHASE_WORDS   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam logic [2:0] CMD_LAST = 3'd7;  // highest encodable cmd, 5..7 unused

  typedef enum int {
    MIX_RX_FILL,
    MIX_RX_DRAIN,
    MIX_TX_FILL,
    MIX_TX_DRAIN,
    MIX_NOISE
  } traffic_mix_e;

  // Mirror of the buffers and flow control state, plus the results it owes.
  class uart_buffer_mirror;
    logic       cts_en, cts_lvl, rts_en, rts_lvl;
    logic [5:0] cts_thr;
    logic       cts_clear;
    logic [7:0] rx_mem[RX_DEPTH];
    logic [7:0] tx_mem[TX_DEPTH];
    int         rx_wr, rx_rd, rx_count;
    int         tx_wr, tx_rd, tx_count;
    out_word_t  owed_results[$];
    int         err_cnt;
    int         result_idx;

    function new();
      cts_en = 1'b0; cts_lvl = 1'b0; cts_thr = CTS_THR_RESET;
      rts_en = 1'b0; rts_lvl = 1'b0;
      cts_clear = 1'b1;
      rx_wr = 0; rx_rd = 0; rx_count = 0;
      tx_wr = 0; tx_rd = 0; tx_count = 0;
      err_cnt = 0;
      result_idx = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CTS_EN:    cts_en  = val[0];
        CFG_CTS_LEVEL: cts_lvl = val[0];
        CFG_CTS_THR:   cts_thr = val;
        CFG_RTS_EN:    rts_en  = val[0];
        CFG_RTS_LEVEL: rts_lvl = val[0];
        default: ;
      endcase
      // a CTS register write with CTS enabled re-derives CTS from the fill level
      if (cts_en && (idx == CFG_CTS_EN || idx == CFG_CTS_LEVEL || idx == CFG_CTS_THR))
        cts_clear = (rx_count < cts_thr);
    endfunction

    function out_word_t next_result(in_word_t w);
      out_word_t r;
      r = '0;
      r.status = ST_OK;
      case (w.cmd)
        CMD_RX: begin
          if (w.rx_error_flags != 3'b000) begin
            r.status = ST_RX_ERR;
          end else if (rx_count >= RX_DEPTH) begin
            r.status = ST_RX_OVF;
          end else begin
            rx_mem[rx_wr] = w.data_in;
            rx_wr = (rx_wr + 1) % RX_DEPTH;
            rx_count++;
            if (cts_en && rx_count >= cts_thr) cts_clear = 1'b0;
          end
        end
        CMD_TX_DONE: begin
          if (rts_en && w.rts_level != rts_lvl) begin
            r.status = ST_RTS_HOLD;
          end else if (tx_count != 0) begin
            r.tx_byte   = tx_mem[tx_rd];
            r.tx_strobe = 1'b1;
            tx_rd = (tx_rd + 1) % TX_DEPTH;
            tx_count--;
          end
        end
        CMD_WRITE: begin
          if (tx_count >= TX_DEPTH) begin
            r.status = ST_TX_FULL;
          end else if (tx_count != 0 || !w.tx_reg_free) begin
            tx_mem[tx_wr] = w.data_in;
            tx_wr = (tx_wr + 1) % TX_DEPTH;
            tx_count++;
          end else begin
            r.tx_byte   = w.data_in;
            r.tx_strobe = 1'b1;
          end
        end
        CMD_READ: begin
          if (rx_count == 0) begin
            r.status = ST_RX_EMPTY;
          end else begin
            r.read_byte = rx_mem[rx_rd];
            rx_rd = (rx_rd + 1) % RX_DEPTH;
            rx_count--;
            if (cts_en && rx_count < cts_thr) cts_clear = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (rx_count == 0) r.status = ST_RX_EMPTY;
          else r.read_byte = rx_mem[rx_rd];
        end
        default: ;
      endcase
      r.cts_level = cts_en ? (cts_clear ? cts_lvl : ~cts_lvl) : 1'b0;
      r.rx_fill   = 6'(rx_count);
      r.tx_fill   = 6'(tx_count);
      return r;
    endfunction

    function void take_event(in_word_t w);
      owed_results.push_back(next_result(w));
    endfunction

    task report(string what);
      if (err_cnt < 100) $display("%0t ns: mismatch: %s", $time, what);
      err_cnt++;
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %h want %h", result_idx, name, got, want));
    endtask

    task match_result(out_word_t got);
      out_word_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result word %h with nothing owed", got));
        return;
      end
      want = owed_results.pop_front();
      cmp_field("read_byte", got.read_byte, want.read_byte);
      cmp_field("tx_byte", got.tx_byte, want.tx_byte);
      cmp_field("tx_strobe", 8'(got.tx_strobe), 8'(want.tx_strobe));
      cmp_field("cts_level", 8'(got.cts_level), 8'(want.cts_level));
      cmp_field("rx_fill", 8'(got.rx_fill), 8'(want.rx_fill));
      cmp_field("tx_fill", 8'(got.tx_fill), 8'(want.tx_fill));
      cmp_field("status", 8'(got.status), 8'(want.status));
      result_idx++;
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  uart_buffer_mirror mirror;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;

  uart_buffer_flow_control_core #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // result side: check accepted words, then pick ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mirror.match_result(out_data_o);
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[uart_buffer_flow_control_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_word_t make_word(logic [2:0] cmd, logic [7:0] data,
                                         logic [2:0] flags, logic reg_free,
                                         logic rts);
    in_word_t w;
    w.cmd            = cmd;
    w.data_in        = data;
    w.rx_error_flags = flags;
    w.tx_reg_free    = reg_free;
    w.rts_level      = rts;
    return w;
  endfunction

  function automatic in_word_t random_word(traffic_mix_e mix);
    in_word_t w;
    int       pick;
    w = make_word(3'($urandom_range(CMD_LAST)), 8'($urandom), 3'($urandom),
                  1'($urandom), 1'($urandom));
    pick = $urandom_range(99);
    case (mix)
      MIX_RX_FILL: begin
        if (pick < 85) begin
          w.cmd = CMD_RX;
          w.rx_error_flags = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 1)) : 3'b000;
        end
      end
      MIX_RX_DRAIN: begin
        if (pick < 60) w.cmd = CMD_READ;
        else if (pick < 85) w.cmd = CMD_PEEK;
      end
      MIX_TX_FILL: begin
        if (pick < 85) begin
          w.cmd = CMD_WRITE;
          w.tx_reg_free = ($urandom_range(4) == 0);
        end
      end
      MIX_TX_DRAIN: begin
        if (pick < 80) begin
          w.cmd = CMD_TX_DONE;
          w.rts_level = ($urandom_range(3) == 0) ? ~mirror.rts_lvl : mirror.rts_lvl;
        end else if (pick < 90) begin
          w.cmd = CMD_WRITE;
          w.tx_reg_free = 1'b1;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // offer one word and hold it until the core takes it
  task send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.take_event(w);
  endtask

  task wait_idle();
    in_valid_i <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mirror.write_reg(idx, val);
  endtask

  // threshold goes first so it re-derives CTS under the previous enable
  task set_flow(logic cts_en, logic cts_lvl, logic [5:0] thr, logic rts_en, logic rts_lvl);
    wait_idle();
    write_reg(CFG_CTS_THR, thr);
    write_reg(CFG_CTS_LEVEL, {5'($urandom), cts_lvl});
    write_reg(CFG_RTS_EN, {5'($urandom), rts_en});
    write_reg(CFG_RTS_LEVEL, {5'($urandom), rts_lvl});
    write_reg(CFG_CTS_EN, {5'($urandom), cts_en});
    cfg_we_i <= 1'b0;
  endtask

  task run_phase(int words);
    traffic_mix_e mix;
    int           left;
    left = 0;
    mix  = MIX_NOISE;
    for (int n = 0; n < words; n++) begin
      if (left == 0) begin
        mix  = traffic_mix_e'($urandom_range(MIX_NOISE));
        left = $urandom_range(70, 5);
      end
      left--;
      send_word(random_word(mix));
    end
  endtask

  initial begin
    mirror = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty buffers, unused commands, both byte extremes, every error flag
    send_word(make_word(CMD_PEEK, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_READ, 8'hFF, 3'b111, 1'b1, 1'b1));
    for (int c = CMD_PEEK + 1; c <= CMD_LAST; c++)
      send_word(make_word(3'(c), 8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom)));
    send_word(make_word(CMD_RX, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_RX, 8'hFF, 3'b000, 1'b1, 1'b1));
    send_word(make_word(CMD_RX, 8'h11, 3'b001, 1'b0, 1'b0));
    send_word(make_word(CMD_RX, 8'h22, 3'b010, 1'b0, 1'b0));
    send_word(make_word(CMD_RX, 8'h44, 3'b100, 1'b0, 1'b0));
    send_word(make_word(CMD_RX, 8'h77, 3'b111, 1'b0, 1'b0));
    send_word(make_word(CMD_PEEK, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_READ, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_READ, 8'h00, 3'b000, 1'b0, 1'b0));
    // direct write, then queued writes drained by transmit complete
    send_word(make_word(CMD_WRITE, 8'hA5, 3'b000, 1'b1, 1'b0));
    send_word(make_word(CMD_WRITE, 8'h5A, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_WRITE, 8'hFF, 3'b000, 1'b1, 1'b0));
    send_word(make_word(CMD_TX_DONE, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_TX_DONE, 8'h00, 3'b000, 1'b0, 1'b1));
    send_word(make_word(CMD_TX_DONE, 8'h00, 3'b000, 1'b1, 1'b0));

    // RTS hold, direct write ignoring RTS, CTS toggling at threshold one
    set_flow(1'b1, 1'b1, 6'd1, 1'b1, 1'b1);
    send_word(make_word(CMD_WRITE, 8'h3C, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_TX_DONE, 8'h00, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_TX_DONE, 8'h00, 3'b000, 1'b0, 1'b1));
    send_word(make_word(CMD_WRITE, 8'hC3, 3'b000, 1'b1, 1'b0));
    send_word(make_word(CMD_RX, 8'h81, 3'b000, 1'b0, 1'b0));
    send_word(make_word(CMD_READ, 8'h00, 3'b000, 1'b0, 1'b0));

    send_idle_pct = 38;
    recv_idle_pct = 72;
    set_flow(1'b1, 1'b0, 6'd32, 1'b0, 1'b0);
    run_phase(PHASE_WORDS);
    set_flow(1'b1, 1'b1, 6'd0, 1'b1, 1'b1);
    run_phase(PHASE_WORDS);

    send_idle_pct = 72;
    recv_idle_pct = 38;
    set_flow(1'b1, 1'b1, 6'($urandom_range(30, 2)), 1'b1, 1'b0);
    run_phase(PHASE_WORDS);
    set_flow(1'b0, 1'b1, 6'd63, 1'b0, 1'b1);
    run_phase(PHASE_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_flow(1'b1, 1'b0, 6'd1, 1'b1, 1'b1);
    run_phase(PHASE_WORDS);
    set_flow(1'b1, 1'($urandom), 6'd31, 1'($urandom), 1'($urandom));
    run_phase(PHASE_WORDS);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mirror.err_cnt == 0 && mirror.owed_results.size() == 0) begin
      $display("[uart_buffer_flow_control_core] OK");
    end else begin
      $display("[uart_buffer_flow_control_core] ERROR");
    end
    $finish;
  end

endmodule
